@@ design/ffha_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared opcodes, result codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // request kinds
  localparam logic OPN_ALLOC = 1'b0;
  localparam logic OPN_FREE  = 1'b1;

  // result codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [1:0] CFG_INIT_PAGES = 2'd1;
  localparam logic [1:0] CFG_MAX_PAGES  = 2'd2;

  // datapath commands
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP         = 5'd0;
  localparam logic [OP_W-1:0] OP_INIT        = 5'd1;
  localparam logic [OP_W-1:0] OP_LOAD        = 5'd2;
  localparam logic [OP_W-1:0] OP_RD          = 5'd3;
  localparam logic [OP_W-1:0] OP_NEXT        = 5'd4;
  localparam logic [OP_W-1:0] OP_TAKE        = 5'd5;
  localparam logic [OP_W-1:0] OP_SPLIT_BEGIN = 5'd6;
  localparam logic [OP_W-1:0] OP_SH_RD       = 5'd7;
  localparam logic [OP_W-1:0] OP_SH_WR       = 5'd8;
  localparam logic [OP_W-1:0] OP_SPLIT_LO    = 5'd9;
  localparam logic [OP_W-1:0] OP_SPLIT_HI    = 5'd10;
  localparam logic [OP_W-1:0] OP_MISS        = 5'd11;
  localparam logic [OP_W-1:0] OP_GROW        = 5'd12;
  localparam logic [OP_W-1:0] OP_OOM         = 5'd13;
  localparam logic [OP_W-1:0] OP_BADFREE     = 5'd14;
  localparam logic [OP_W-1:0] OP_HIT         = 5'd15;
  localparam logic [OP_W-1:0] OP_NX_RD       = 5'd16;
  localparam logic [OP_W-1:0] OP_MERGE_NX    = 5'd17;
  localparam logic [OP_W-1:0] OP_RM_RD       = 5'd18;
  localparam logic [OP_W-1:0] OP_RM_WR       = 5'd19;
  localparam logic [OP_W-1:0] OP_RM_END      = 5'd20;
  localparam logic [OP_W-1:0] OP_CUR_WR      = 5'd21;
  localparam logic [OP_W-1:0] OP_PV_RD       = 5'd22;
  localparam logic [OP_W-1:0] OP_MERGE_PV    = 5'd23;
  localparam logic [OP_W-1:0] OP_OUT         = 5'd24;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } ffha_cmd_t;

  typedef struct packed {
    logic zero;      // zero-size allocate
    logic is_free;   // current item is a free
    logic fit;       // entry read back is free and large enough
    logic split_ok;  // fitting entry can be split
    logic hit;       // entry read back is the used block being freed
    logic last;      // scan index is the last table entry
    logic grow_ok;   // heap can grow for this miss
    logic has_next;
    logic has_prev;
    logic rd_free;   // entry read back is free
    logic sh_more;   // insert shift not done
    logic rm_more;   // remove shift not done
  } ffha_stat_t;

endpackage

@@ design/ffha_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/ffha_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer: table scan, split/merge shifts, heap growth and result handoff.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic                cfg_write,
  input  ffha_pkg::ffha_stat_t st,
  output ffha_pkg::ffha_cmd_t  cmd
);
  import ffha_pkg::*;

  localparam logic [4:0] S_INIT     = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_RD       = 5'd2;
  localparam logic [4:0] S_CHK      = 5'd3;
  localparam logic [4:0] S_GROW     = 5'd4;
  localparam logic [4:0] S_SH_RD    = 5'd5;
  localparam logic [4:0] S_SH_WR    = 5'd6;
  localparam logic [4:0] S_SPLIT_LO = 5'd7;
  localparam logic [4:0] S_SPLIT_HI = 5'd8;
  localparam logic [4:0] S_NX_RD    = 5'd9;
  localparam logic [4:0] S_NX_CHK   = 5'd10;
  localparam logic [4:0] S_RM_RD    = 5'd11;
  localparam logic [4:0] S_RM_WR    = 5'd12;
  localparam logic [4:0] S_CUR_WR   = 5'd13;
  localparam logic [4:0] S_PV_RD    = 5'd14;
  localparam logic [4:0] S_PV_CHK   = 5'd15;
  localparam logic [4:0] S_DONE     = 5'd16;

  logic [4:0] state, state_next;
  logic       pend, pend_next;
  logic       rm_prev, rm_prev_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE) || pend;

  always_comb begin
    state_next   = state;
    rm_prev_next = rm_prev;
    cmd.op       = OP_NOP;
    pend_next    = cfg_write || (pend && (state != S_INIT));
    unique case (state)
      S_INIT: begin
        cmd.op     = OP_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (pend) begin
          state_next = S_INIT;
        end else if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (st.zero) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_RD;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (!st.is_free) begin
          if (st.fit) begin
            if (st.split_ok) begin
              cmd.op     = OP_SPLIT_BEGIN;
              state_next = S_SH_RD;
            end else begin
              cmd.op     = OP_TAKE;
              state_next = S_DONE;
            end
          end else if (st.last) begin
            cmd.op     = OP_MISS;
            state_next = S_GROW;
          end else begin
            cmd.op     = OP_NEXT;
            state_next = S_RD;
          end
        end else begin
          if (st.hit) begin
            cmd.op     = OP_HIT;
            state_next = S_NX_RD;
          end else if (st.last) begin
            cmd.op     = OP_BADFREE;
            state_next = S_DONE;
          end else begin
            cmd.op     = OP_NEXT;
            state_next = S_RD;
          end
        end
      end
      S_GROW: begin
        if (st.grow_ok) begin
          cmd.op     = OP_GROW;
          state_next = S_RD;
        end else begin
          cmd.op     = OP_OOM;
          state_next = S_DONE;
        end
      end
      S_SH_RD: begin
        if (st.sh_more) begin
          cmd.op     = OP_SH_RD;
          state_next = S_SH_WR;
        end else begin
          state_next = S_SPLIT_LO;
        end
      end
      S_SH_WR: begin
        cmd.op     = OP_SH_WR;
        state_next = S_SH_RD;
      end
      S_SPLIT_LO: begin
        cmd.op     = OP_SPLIT_LO;
        state_next = S_SPLIT_HI;
      end
      S_SPLIT_HI: begin
        cmd.op     = OP_SPLIT_HI;
        state_next = S_DONE;
      end
      S_NX_RD: begin
        if (st.has_next) begin
          cmd.op     = OP_NX_RD;
          state_next = S_NX_CHK;
        end else begin
          state_next = S_CUR_WR;
        end
      end
      S_NX_CHK: begin
        if (st.rd_free) begin
          cmd.op       = OP_MERGE_NX;
          rm_prev_next = 1'b0;
          state_next   = S_RM_RD;
        end else begin
          state_next = S_CUR_WR;
        end
      end
      S_RM_RD: begin
        if (st.rm_more) begin
          cmd.op     = OP_RM_RD;
          state_next = S_RM_WR;
        end else begin
          cmd.op     = OP_RM_END;
          state_next = rm_prev ? S_DONE : S_CUR_WR;
        end
      end
      S_RM_WR: begin
        cmd.op     = OP_RM_WR;
        state_next = S_RM_RD;
      end
      S_CUR_WR: begin
        cmd.op     = OP_CUR_WR;
        state_next = S_PV_RD;
      end
      S_PV_RD: begin
        if (st.has_prev) begin
          cmd.op     = OP_PV_RD;
          state_next = S_PV_CHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_PV_CHK: begin
        if (st.rd_free) begin
          cmd.op       = OP_MERGE_PV;
          rm_prev_next = 1'b1;
          state_next   = S_RM_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
    out_valid_next = (out_valid && out_stall) || (cmd.op == OP_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      pend      <= 1'b0;
      rm_prev   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= pend_next;
      rm_prev   <= rm_prev_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ design/ffha_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_dp
// Block table RAM, scan/shift pointers, heap counters and result registers.
// ----------------------------------------------------------------------------
module ffha_dp #(
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 16,
  parameter int PAGE_BYTES   = 4096,
  parameter int MIN_GROW     = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [47:0]          cfg_data,
  input  logic                 operation,
  input  logic [27:0]          request_size,
  input  logic [47:0]          free_address,
  output logic [47:0]          result_address,
  output logic [1:0]           status,
  output logic [27:0]          used_bytes,
  output logic [27:0]          free_bytes,
  output logic [8:0]           block_count,
  output logic [27:0]          heap_bytes,
  input  ffha_pkg::ffha_cmd_t  cmd,
  output ffha_pkg::ffha_stat_t st
);
  import ffha_pkg::*;

  localparam int SHIFT  = $clog2(PAGE_BYTES);
  localparam int OFF_W  = (16 + SHIFT > 30) ? 16 + SHIFT : 30;
  localparam int EW     = 2 * OFF_W + 1;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam logic [OFF_W-1:0] HDR   = OFF_W'(HEADER_BYTES);
  localparam logic [OFF_W-1:0] PGM1  = OFF_W'(PAGE_BYTES - 1);
  localparam logic [OFF_W-1:0] MING  = OFF_W'(MIN_GROW);
  localparam logic [CNT_W-1:0] CMAX  = CNT_W'(MAX_BLOCKS);

  // configuration
  logic [47:0] heap_base;
  logic [15:0] start_pages, page_limit;

  // state
  logic [CNT_W-1:0] cnt, k;
  logic [IDX_W-1:0] idx;
  logic [EW-1:0]    ent, cur;
  logic [15:0]      pages;
  logic [OFF_W-1:0] used_sum, free_sum, sz;
  logic [47:0]      target, fa;
  logic             is_free, zero, retried;

  // RAM
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [EW-1:0]    wdata, rdata;

  ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  logic             rd_used, ent_used;
  logic [OFF_W-1:0] rd_start, rd_size, ent_start, ent_size, cur_start, cur_size;
  assign rd_used   = rdata[EW-1];
  assign rd_size   = rdata[2*OFF_W-1:OFF_W];
  assign rd_start  = rdata[OFF_W-1:0];
  assign ent_used  = ent[EW-1];
  assign ent_size  = ent[2*OFF_W-1:OFF_W];
  assign ent_start = ent[OFF_W-1:0];
  assign cur_size  = cur[2*OFF_W-1:OFF_W];
  assign cur_start = cur[OFF_W-1:0];

  // effective page counts
  logic [15:0]      ei, mraw, cap;
  logic [OFF_W-1:0] init_size, pages_bytes;
  assign ei          = (start_pages == 16'd0) ? 16'd1 : start_pages;
  assign mraw        = (page_limit == 16'd0) ? 16'd1 : page_limit;
  assign cap         = (mraw < ei) ? ei : mraw;
  assign init_size   = (OFF_W'(ei) << SHIFT) - HDR;
  assign pages_bytes = OFF_W'(pages) << SHIFT;

  // growth amount
  logic [OFF_W-1:0] need0, need1, room, need, added;
  always_comb begin
    need0 = (sz + HDR + PGM1) >> SHIFT;
    need1 = (need0 < MING) ? MING : need0;
    room  = OFF_W'(cap - pages);
    need  = (need1 > room) ? room : need1;
    added = need << SHIFT;
  end

  // request decode
  logic [28:0]      req_rnd;
  logic [CNT_W-1:0] idx_c, idx_p1, k_m1, k_p1, cnt_m1;
  logic [47:0]      rd_uaddr;
  assign req_rnd  = {1'b0, request_size} + 29'd7;
  assign idx_c    = CNT_W'(idx);
  assign idx_p1   = idx_c + 1'b1;
  assign k_m1     = k - 1'b1;
  assign k_p1     = k + 1'b1;
  assign cnt_m1   = cnt - 1'b1;
  assign rd_uaddr = 48'(rd_start);

  always_comb begin
    st.zero     = zero;
    st.is_free  = is_free;
    st.fit      = !rd_used && (rd_size >= sz);
    st.split_ok = (rd_size >= sz + HDR + OFF_W'(8)) && (cnt < CMAX);
    st.hit      = rd_used && (rd_uaddr == target);
    st.last     = (idx_p1 == cnt);
    st.grow_ok  = !retried && (pages < cap) && (!ent_used || (cnt < CMAX));
    st.has_next = (idx_p1 < cnt);
    st.has_prev = (idx != '0);
    st.rd_free  = !rd_used;
    st.sh_more  = (k > idx_p1);
    st.rm_more  = (k_p1 < cnt);
  end

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = cur;
    raddr = idx;
    case (cmd.op)
      OP_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {1'b0, init_size, {OFF_W{1'b0}}};
      end
      OP_SH_RD: raddr = k_m1[IDX_W-1:0];
      OP_NX_RD: raddr = idx_p1[IDX_W-1:0];
      OP_RM_RD: raddr = k_p1[IDX_W-1:0];
      OP_PV_RD: raddr = idx - 1'b1;
      OP_SH_WR, OP_RM_WR: begin
        we    = 1'b1;
        waddr = k[IDX_W-1:0];
        wdata = rdata;
      end
      OP_TAKE: begin
        we    = 1'b1;
        wdata = {1'b1, rd_size, rd_start};
      end
      OP_SPLIT_LO: begin
        we    = 1'b1;
        waddr = idx_p1[IDX_W-1:0];
        wdata = {1'b0, cur_size - sz - HDR, cur_start + HDR + sz};
      end
      OP_SPLIT_HI: begin
        we    = 1'b1;
        wdata = {1'b1, sz, cur_start};
      end
      OP_GROW: begin
        we = 1'b1;
        if (!ent_used) begin
          waddr = cnt_m1[IDX_W-1:0];
          wdata = {1'b0, ent_size + added, ent_start};
        end else begin
          waddr = cnt[IDX_W-1:0];
          wdata = {1'b0, added - HDR, pages_bytes};
        end
      end
      OP_CUR_WR: we = 1'b1;
      OP_MERGE_PV: begin
        we    = 1'b1;
        waddr = idx - 1'b1;
        wdata = {1'b0, rd_size + HDR + cur_size, rd_start};
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base   <= '0;
      start_pages <= 16'd16;
      page_limit  <= 16'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HEAP_BASE:  heap_base   <= cfg_data;
        CFG_INIT_PAGES: start_pages <= cfg_data[15:0];
        CFG_MAX_PAGES:  page_limit  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [31:0] cnt32;
  assign cnt32 = 32'(cnt);

  logic [1:0]  code;
  logic [47:0] addr;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT: begin
        cnt      <= CNT_W'(1);
        pages    <= ei;
        used_sum <= '0;
        free_sum <= init_size;
      end
      OP_LOAD: begin
        is_free <= operation == OPN_FREE;
        zero    <= (operation == OPN_ALLOC) && (request_size == 28'd0);
        code    <= ((operation == OPN_ALLOC) && (request_size == 28'd0)) ? ST_ZERO : ST_OK;
        addr    <= '0;
        sz      <= OFF_W'({req_rnd[28:3], 3'b000});
        fa      <= free_address;
        target  <= free_address - heap_base - 48'(HEADER_BYTES);
        idx     <= '0;
        retried <= 1'b0;
      end
      OP_NEXT: idx <= idx + 1'b1;
      OP_TAKE: begin
        used_sum <= used_sum + rd_size;
        free_sum <= free_sum - rd_size;
        addr     <= heap_base + rd_uaddr + 48'(HEADER_BYTES);
      end
      OP_SPLIT_BEGIN: begin
        cur <= rdata;
        k   <= cnt;
      end
      OP_SH_WR: k <= k_m1;
      OP_SPLIT_HI: begin
        cnt      <= cnt + 1'b1;
        used_sum <= used_sum + sz;
        free_sum <= free_sum - sz - HDR;
        addr     <= heap_base + 48'(cur_start) + 48'(HEADER_BYTES);
      end
      OP_MISS: ent <= rdata;
      OP_GROW: begin
        if (!ent_used) begin
          free_sum <= free_sum + added;
        end else begin
          free_sum <= free_sum + added - HDR;
          cnt      <= cnt + 1'b1;
        end
        pages   <= pages + need[15:0];
        retried <= 1'b1;
        idx     <= '0;
      end
      OP_OOM: code <= ST_OOM;
      OP_BADFREE: code <= (fa == 48'd0) ? ST_OK : ST_BAD;
      OP_HIT: begin
        cur      <= {1'b0, rd_size, rd_start};
        used_sum <= used_sum - rd_size;
        free_sum <= free_sum + rd_size;
      end
      OP_MERGE_NX: begin
        cur      <= {1'b0, cur_size + HDR + rd_size, cur_start};
        free_sum <= free_sum + HDR;
        k        <= idx_p1;
      end
      OP_RM_WR: k <= k_p1;
      OP_RM_END: cnt <= cnt_m1;
      OP_MERGE_PV: begin
        free_sum <= free_sum + HDR;
        k        <= idx_c;
      end
      OP_OUT: begin
        result_address <= addr;
        status         <= code;
        used_bytes     <= used_sum[27:0];
        free_bytes     <= free_sum[27:0];
        block_count    <= cnt32[8:0];
        heap_bytes     <= pages_bytes[27:0];
      end
      default: ;
    endcase
  end

endmodule

@@ design/first_fit_heap_allocator.sv @@
`timescale 1ns / 1ps
// Sequence: an allocate scans table entries in order, then shifts entries up on a split;
//   a miss adds one growth step and a full rescan. A free scans entries in order and
//   shifts entries down on each merge.
// Throughput: one item at a time; the block table RAM (one read and one write port)
//   sets the pace.
// Reset (and any config write): table entry 0 is rewritten, with no clearing pass.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap block table with split, growth and coalescing on free.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 16,
  parameter int PAGE_BYTES   = 4096,
  parameter int MIN_GROW     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [27:0] request_size,
  input  logic [47:0] free_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] result_address,
  output logic [1:0]  status,
  output logic [27:0] used_bytes,
  output logic [27:0] free_bytes,
  output logic [8:0]  block_count,
  output logic [27:0] heap_bytes
);
  import ffha_pkg::*;

  ffha_cmd_t  cmd;
  ffha_stat_t st;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cfg_write(cfg_write),
    .st       (st),
    .cmd      (cmd)
  );

  ffha_dp #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES),
    .PAGE_BYTES  (PAGE_BYTES),
    .MIN_GROW    (MIN_GROW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .request_size  (request_size),
    .free_address  (free_address),
    .result_address(result_address),
    .status        (status),
    .used_bytes    (used_bytes),
    .free_bytes    (free_bytes),
    .block_count   (block_count),
    .heap_bytes    (heap_bytes),
    .cmd           (cmd),
    .st            (st)
  );

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous item in flight");

  // failures and frees never report an address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (result_address == 48'd0))
    else $error("nonzero address on failed item");

  // a config write forces a table rebuild before the next item
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> in_stall)
    else $error("item taken before heap reinit");

endmodule

@@ verif/first_fit_heap_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives allocate/free items through the heap allocator under random idling.
// It predicts every result with its own block-table model and steps through
// several register settings: wrapped base, one-page heaps, cap below the
// initial size, a table filled to the limit and the largest heap.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int          TBL_DEPTH = 256;
  localparam longint      HDR       = 16;
  localparam longint      PG        = 4096;
  localparam longint      GROW_MIN  = 16;
  localparam logic [47:0] MASK48    = 48'hFFFF_FFFF_FFFF;
  localparam int          WDOG_MAX  = 40000;
  localparam int          HOLD_OFF  = 3000;

  typedef struct {
    logic [47:0] addr;
    logic [1:0]  st;
    logic [27:0] used;
    logic [27:0] freeb;
    logic [8:0]  cnt;
    logic [27:0] heap;
  } heap_result_t;

  class alloc_scoreboard;
    longint unsigned base, ini_pages, cap_pages, pages;
    longint unsigned bstart[TBL_DEPTH];
    longint unsigned bsize[TBL_DEPTH];
    bit              bused[TBL_DEPTH];
    int              nblk;
    heap_result_t    expected_q[$];
    logic [47:0]     last_freed;
    int errors, n_alloc, n_free, n_oom, n_bad, n_full;

    function new();
      base = 0; ini_pages = 16; cap_pages = 256;
      reinit();
    endfunction

    function longint unsigned eff_ini();
      return ini_pages == 0 ? 1 : ini_pages;
    endfunction

    function longint unsigned eff_cap();
      longint unsigned m;
      m = cap_pages == 0 ? 1 : cap_pages;
      return m < eff_ini() ? eff_ini() : m;
    endfunction

    function void reinit();
      for (int i = 0; i < TBL_DEPTH; i++) begin
        bstart[i] = 0; bsize[i] = 0; bused[i] = 0;
      end
      pages = eff_ini();
      bsize[0] = pages * PG - HDR;
      nblk = 1;
    endfunction

    function void write_reg(logic [1:0] idx, logic [47:0] v);
      case (idx)
        CFG_HEAP_BASE:  base = v;
        CFG_INIT_PAGES: ini_pages = v[15:0];
        CFG_MAX_PAGES:  cap_pages = v[15:0];
        default: return;
      endcase
      reinit();
    endfunction

    function logic [47:0] user_addr(int i);
      return (base + bstart[i] + HDR) & MASK48;
    endfunction

    function void drop_entry(int idx);
      for (int k = idx; k + 1 < nblk; k++) begin
        bstart[k] = bstart[k+1]; bsize[k] = bsize[k+1]; bused[k] = bused[k+1];
      end
      nblk--;
    endfunction

    function int take_fit(longint unsigned sz);
      for (int i = 0; i < nblk; i++) begin
        if (bused[i] || bsize[i] < sz) continue;
        if (bsize[i] >= sz + HDR + 8) begin
          if (nblk < TBL_DEPTH) begin
            for (int k = nblk; k > i + 1; k--) begin
              bstart[k] = bstart[k-1]; bsize[k] = bsize[k-1]; bused[k] = bused[k-1];
            end
            bstart[i+1] = bstart[i] + HDR + sz;
            bsize[i+1]  = bsize[i] - sz - HDR;
            bused[i+1]  = 0;
            bsize[i]    = sz;
            nblk++;
          end else begin
            n_full++;
          end
        end
        bused[i] = 1;
        return i;
      end
      return -1;
    endfunction

    function bit extend_heap(longint unsigned want_bytes);
      longint unsigned cap, need, room, added;
      cap = eff_cap();
      if (pages >= cap) return 0;
      need = (want_bytes + PG - 1) / PG;
      if (need < GROW_MIN) need = GROW_MIN;
      room = cap - pages;
      if (need > room) need = room;
      if (need == 0) return 0;
      added = need * PG;
      if (!bused[nblk-1]) begin
        bsize[nblk-1] += added;
      end else begin
        if (nblk >= TBL_DEPTH) begin
          n_full++;
          return 0;
        end
        bstart[nblk] = pages * PG;
        bsize[nblk]  = added - HDR;
        bused[nblk]  = 0;
        nblk++;
      end
      pages += need;
      return 1;
    endfunction

    // Random user address of a block in use; 0 when none.
    function logic [47:0] pick_live();
      int s;
      s = $urandom_range(0, nblk - 1);
      for (int j = 0; j < nblk; j++)
        if (bused[(s + j) % nblk]) return user_addr((s + j) % nblk);
      return 0;
    endfunction

    function void note_item(logic op, logic [27:0] rs, logic [47:0] fa);
      heap_result_t r;
      longint unsigned sz, usum, fsum;
      int idx;
      r.addr = 0; r.st = ST_OK;
      if (op == OPN_ALLOC) begin
        n_alloc++;
        if (rs == 0) begin
          r.st = ST_ZERO;
        end else begin
          sz = (longint'(rs) + 7) & ~longint'(7);
          idx = take_fit(sz);
          if (idx < 0 && extend_heap(sz + HDR)) idx = take_fit(sz);
          if (idx < 0) begin
            r.st = ST_OOM;
            n_oom++;
          end else begin
            r.addr = user_addr(idx);
          end
        end
      end else begin
        n_free++;
        idx = -1;
        for (int i = 0; i < nblk; i++)
          if (bused[i] && user_addr(i) == fa) begin
            idx = i;
            break;
          end
        if (idx < 0) begin
          r.st = (fa == 0) ? ST_OK : ST_BAD;
          if (fa != 0) n_bad++;
        end else begin
          last_freed = fa;
          bused[idx] = 0;
          if (idx + 1 < nblk && !bused[idx+1]) begin
            bsize[idx] += HDR + bsize[idx+1];
            drop_entry(idx + 1);
          end
          if (idx > 0 && !bused[idx-1]) begin
            bsize[idx-1] += HDR + bsize[idx];
            drop_entry(idx);
          end
        end
      end
      usum = 0; fsum = 0;
      for (int i = 0; i < nblk; i++)
        if (bused[i]) usum += bsize[i];
        else fsum += bsize[i];
      r.used = usum[27:0]; r.freeb = fsum[27:0];
      r.cnt = nblk[8:0];
      r.heap = 28'(pages * PG);
      expected_q.push_back(r);
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, addr %h status %0d",
                 $time, got.addr, got.st);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.addr !== e.addr) begin
        $display("%0t: result_address exp %h got %h", $time, e.addr, got.addr); errors++;
      end
      if (got.st !== e.st) begin
        $display("%0t: status exp %0d got %0d", $time, e.st, got.st); errors++;
      end
      if (got.used !== e.used) begin
        $display("%0t: used_bytes exp %0d got %0d", $time, e.used, got.used); errors++;
      end
      if (got.freeb !== e.freeb) begin
        $display("%0t: free_bytes exp %0d got %0d", $time, e.freeb, got.freeb); errors++;
      end
      if (got.cnt !== e.cnt) begin
        $display("%0t: block_count exp %0d got %0d", $time, e.cnt, got.cnt); errors++;
      end
      if (got.heap !== e.heap) begin
        $display("%0t: heap_bytes exp %0d got %0d", $time, e.heap, got.heap); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_write = 0;
  logic [1:0]  cfg_index = CFG_HEAP_BASE;
  logic [47:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        operation = OPN_ALLOC;
  logic [27:0] request_size = 0;
  logic [47:0] free_address = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [47:0] result_address;
  logic [1:0]  status;
  logic [27:0] used_bytes, free_bytes, heap_bytes;
  logic [8:0]  block_count;

  alloc_scoreboard heap_sb = new();
  bit quiet_mode = 0;   // no idling on either side
  bit hold_req   = 0;
  int phases     = 0;
  int idle_count = 0;

  always #4 clk = ~clk;

  first_fit_heap_allocator DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .request_size(request_size), .free_address(free_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_address(result_address), .status(status), .used_bytes(used_bytes),
    .free_bytes(free_bytes), .block_count(block_count), .heap_bytes(heap_bytes)
  );

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task send_item(logic op, logic [27:0] rs, logic [47:0] fa);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    operation <= op; request_size <= rs; free_address <= fa;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    heap_sb.note_item(op, rs, fa);
  endtask

  task alloc(logic [27:0] rs);
    send_item(OPN_ALLOC, rs, 48'($urandom()));
  endtask

  task release_addr(logic [47:0] fa);
    send_item(OPN_FREE, 28'($urandom()), fa);
  endtask

  task wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (heap_sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task program_heap(logic [47:0] b, logic [15:0] ini, logic [15:0] mx);
    logic [47:0] vals[3];
    logic [1:0]  idxs[3];
    wait_drained();
    vals = '{b, {32'h0, ini}, {32'h0, mx}};
    idxs = '{CFG_HEAP_BASE, CFG_INIT_PAGES, CFG_MAX_PAGES};
    for (int i = 0; i < 3; i++) begin
      cfg_write <= 1; cfg_index <= idxs[i]; cfg_data <= vals[i];
      @(posedge clk);
      heap_sb.write_reg(idxs[i], vals[i]);
    end
    cfg_write <= 0;
    phases++;
  endtask

  // Mostly small sizes; a few large ones and whole-field values.
  function logic [27:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 70) return 28'($urandom_range(1, 256));
    if (r < 90) return 28'($urandom_range(257, 8192));
    if (r < 97) return 28'($urandom_range(8193, 200000));
    return 28'($urandom() & 28'hFFF_FFFF);
  endfunction

  task random_item();
    int r;
    logic [47:0] a;
    r = $urandom_range(0, 99);
    a = heap_sb.pick_live();
    if (r < 50) begin
      alloc(pick_size());
    end else if (r < 88 && a != 0) begin
      release_addr(a);
    end else begin
      case ($urandom_range(0, 3))
        0: release_addr(48'({$urandom(), $urandom()} & MASK48));
        1: release_addr(0);
        2: release_addr(a + 48'd8);
        default: release_addr(heap_sb.last_freed);
      endcase
    end
  endtask

  task random_run(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
      random_item();
    end
    quiet_mode = 0;
  endtask

  // Result side: random stall, plus one long hold-off on request.
  initial begin
    heap_result_t got;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.addr = result_address; got.st = status; got.used = used_bytes;
        got.freeb = free_bytes; got.cnt = block_count; got.heap = heap_bytes;
        heap_sb.check_result(got);
      end
      if (hold_req) begin
        out_stall <= 1;
        repeat (HOLD_OFF) @(posedge clk);
        hold_req = 0;
        out_stall <= 0;
      end else if (quiet_mode) begin
        out_stall <= 0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 25);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_req) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WDOG_MAX) begin
      $display("watchdog expired at %0t", $time);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [47:0] a;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset defaults: field extremes, both operations, bad and double free
    alloc(0);
    alloc(1);
    alloc(8);
    a = heap_sb.pick_live();
    alloc(28'hFFF_FFFF);
    alloc(70000);
    release_addr(a);
    release_addr(a);
    release_addr(0);
    release_addr(MASK48);
    release_addr(48'h5555_AAAA_5555);
    alloc(9);
    random_run(220);

    // wrapped base, one page and no room to grow
    program_heap(48'hFFFF_FFFF_FFF0, 1, 1);
    alloc(4096);
    alloc(4080);
    alloc(1);
    release_addr(heap_sb.pick_live());
    random_run(120);

    // zero pages act as one
    program_heap(48'({$urandom(), $urandom()} & MASK48), 0, 0);
    alloc(4000);
    random_run(80);

    // cap below initial size; fill the table while the receiver holds off
    program_heap(0, 16, 8);
    hold_req = 1;
    for (int i = 0; i < 280; i++) alloc(28'($urandom_range(1, 24)));
    alloc(60000);
    for (int i = 0; i < 40; i++) random_item();

    // largest heap
    program_heap(MASK48, 16'hFFFF, 16'hFFFF);
    alloc(28'hFFF_FFFF);
    alloc(28'h800_0000);
    random_run(80);

    // small start, frequent growth
    program_heap(48'h0000_1234_5000, 2, 16'hFFFF);
    random_run(200);

    wait_drained();
    repeat (1100) @(posedge clk);
    heap_sb.errors += heap_sb.expected_q.size();
    $display("covered %0d allocates (%0d out of memory), %0d frees (%0d rejected),",
             heap_sb.n_alloc, heap_sb.n_oom, heap_sb.n_free, heap_sb.n_bad);
    $display("%0d full-table cases over %0d register settings, %0d mismatches",
             heap_sb.n_full, phases + 1, heap_sb.errors);
    if (heap_sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
